@@ rtl/cpwf_pkg.sv @@
// Shared types and fixed widths for the contact pressure window filter.
package cpwf_pkg;

  // Fixed field widths
  localparam int FORCE_W     = 24;
  localparam int PRESS_W     = 24;
  localparam int SCALE_W     = 16;
  localparam int ROOT_W      = 24;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int MUL_W       = 32;
  localparam int SCALE_FRAC  = 8;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
  localparam logic [PRESS_W-1:0] PRESS_MAX   = {PRESS_W{1'b1}};

  // Sequencer states
  typedef enum logic [3:0] {
    ST_ACC,
    ST_CHECK,
    ST_DIV,
    ST_SQUARE,
    ST_SQ_ADD,
    ST_SQRT,
    ST_SCALE,
    ST_SAT,
    ST_PUSH,
    ST_MEAN,
    ST_OUT
  } state_e;

  // What the shared divider is working on
  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_e;

endpackage

@@ rtl/contact_pressure_window_filter_core.sv @@
// Contact pressure window filter: report accumulation, shared divider, sqrt and history mean.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+-------------------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready | tdata force x,y,z; tlast; tuser no_contact
//  m_axis  | out | m_axis_tvalid/m_axis_tready | tdata pressure; tuser in_contact,dropped
//  cfg     | in  | cfg_valid_i/cfg_ready_o     | pressure_scale (Q8.8)
//
// A contact item that does not close a report is accumulated while the input stays ready.
// A closing item runs the sequencer: check, three divide/square passes, square root,
// scale, saturate, push and mean (only check, push and mean for an empty report), then
// the result waits in the output stage. The per-axis means use a bit-serial divider (one
// quotient bit a cycle), the magnitude a digit-by-digit square root; the history mean
// is one pass of the shared multiplier by a reciprocal. The input is held off meanwhile.
// Reset clears all sums, counters and histories at once; no clearing pass.
module contact_pressure_window_filter_core
  import cpwf_pkg::*;
#(
  parameter int HISTORY_DEPTH = 5,
  parameter int MAX_CONTACTS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [71:0]          s_axis_tdata,  // force_x[23:0], force_y[47:24], force_z[71:48]
  input  logic                 s_axis_tlast,  // last_contact
  input  logic                 s_axis_tuser,  // no_contact
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [PRESS_W-1:0]   m_axis_tdata,  // pressure[23:0]
  output logic [1:0]           m_axis_tuser,  // in_contact[0], contacts_dropped[1]
  // configuration write
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [SCALE_W-1:0]   cfg_data_i
);

  localparam int CNT_W  = $clog2(MAX_CONTACTS + 1);
  localparam int SUM_W  = FORCE_W + CNT_W;
  localparam int HD_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int TOT_W  = PRESS_W + HD_W;
  localparam int DIV_W  = SUM_W;
  localparam int DVS_W  = CNT_W;
  localparam int STEP_W = $clog2(DIV_W + 1);
  localparam int PROD_W = 2 * MUL_W;

  // History mean: multiply by a rounded-up reciprocal, exact for every total below 2**TOT_W
  localparam int          MEAN_SHIFT = TOT_W + $clog2(HISTORY_DEPTH);
  localparam logic [63:0] MEAN_RECIP = ((64'd1 << MEAN_SHIFT) + 64'(HISTORY_DEPTH - 1))
                                       / 64'(HISTORY_DEPTH);

  // ---------------------------------------------------------------------------
  // Registers
  state_e                    state_q, state_d;
  axis_e                     axis_q, axis_d;
  logic [SCALE_W-1:0]        scale_q;
  logic signed [SUM_W-1:0]   sum_x_q, sum_y_q, sum_z_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      ovf_q;
  logic [STEP_W-1:0]         step_q;
  logic [DIV_W-1:0]          dvd_q;
  logic [DVS_W-1:0]          rem_q;
  logic [DVS_W-1:0]          den_q;
  logic [PROD_W-1:0]         prod_q;
  logic [RAD_W-1:0]          sq_q;
  logic [ROOT_W+1:0]         rrem_q;
  logic [ROOT_W-1:0]         root_q;
  logic [PRESS_W-1:0]        newest_q;
  logic                      touched_q;
  logic [TOT_W-1:0]          total_q;
  logic [PRESS_W-1:0]        phist_q [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0]  chist_q;

  // ---------------------------------------------------------------------------
  // Input field unpacking
  logic signed [FORCE_W-1:0] fx, fy, fz;
  logic                      in_fire, out_fire, closing;

  assign fx       = s_axis_tdata[FORCE_W-1:0];
  assign fy       = s_axis_tdata[2*FORCE_W-1:FORCE_W];
  assign fz       = s_axis_tdata[3*FORCE_W-1:2*FORCE_W];
  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = m_axis_tvalid & m_axis_tready;
  assign closing  = s_axis_tuser | s_axis_tlast;

  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Divider operand selection
  logic [SUM_W-1:0] abs_x, abs_y, abs_z;
  logic             div_load;
  logic [DIV_W-1:0] div_src;
  logic [DVS_W-1:0] div_den;

  assign abs_x = sum_x_q[SUM_W-1] ? SUM_W'(-sum_x_q) : SUM_W'(sum_x_q);
  assign abs_y = sum_y_q[SUM_W-1] ? SUM_W'(-sum_y_q) : SUM_W'(sum_y_q);
  assign abs_z = sum_z_q[SUM_W-1] ? SUM_W'(-sum_z_q) : SUM_W'(sum_z_q);

  always_comb begin
    div_load = 1'b0;
    div_src  = '0;
    div_den  = DVS_W'(cnt_q);
    axis_d   = axis_q;
    case (state_q)
      ST_CHECK: begin
        div_load = 1'b1;
        axis_d   = AX_X;
        div_src  = DIV_W'(abs_x);
      end
      ST_SQ_ADD: begin
        if (axis_q == AX_X) begin
          div_load = 1'b1;
          axis_d   = AX_Y;
          div_src  = DIV_W'(abs_y);
        end else if (axis_q == AX_Y) begin
          div_load = 1'b1;
          axis_d   = AX_Z;
          div_src  = DIV_W'(abs_z);
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared restoring divider step: one quotient bit per cycle
  logic [DVS_W:0]   rem_sh;
  logic             div_ge;
  logic [DVS_W:0]   rem_sub;

  assign rem_sh  = {rem_q, dvd_q[DIV_W-1]};
  assign div_ge  = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  // Square root step: two radicand bits per cycle
  logic [ROOT_W+3:0] rrem_sh;
  logic [ROOT_W+3:0] trial;
  logic              sqrt_ge;
  logic [ROOT_W+3:0] rrem_sub;

  assign rrem_sh  = {rrem_q, sq_q[RAD_W-1:RAD_W-2]};
  assign trial    = {2'b00, root_q, 2'b01};
  assign sqrt_ge  = rrem_sh >= trial;
  assign rrem_sub = rrem_sh - trial;

  // Shared multiplier operands
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;

  always_comb begin
    mul_a = MUL_W'(dvd_q);
    mul_b = MUL_W'(dvd_q);
    if (state_q == ST_SCALE) begin
      mul_a = MUL_W'(root_q);
      mul_b = MUL_W'(scale_q);
    end else if (state_q == ST_MEAN) begin
      mul_a = MUL_W'(total_q);
      mul_b = MUL_W'(MEAN_RECIP);
    end
  end

  assign mul_p = mul_a * mul_b;

  // Scaled magnitude and saturation
  logic [PROD_W-SCALE_FRAC-1:0] scaled;
  logic [PRESS_W-1:0]           sat_val;

  assign scaled  = prod_q[PROD_W-1:SCALE_FRAC];
  assign sat_val = (|scaled[PROD_W-SCALE_FRAC-1:PRESS_W]) ? PRESS_MAX : scaled[PRESS_W-1:0];

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACC:    if (in_fire && closing) state_d = ST_CHECK;
      ST_CHECK:  state_d = (cnt_q != '0) ? ST_DIV : ST_PUSH;
      ST_DIV: begin
        if (step_q == STEP_W'(DIV_W - 1)) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: state_d = ST_SQ_ADD;
      ST_SQ_ADD: state_d = (axis_q == AX_Z) ? ST_SQRT : ST_DIV;
      ST_SQRT:   if (step_q == STEP_W'(ROOT_W - 1)) state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_SAT;
      ST_SAT:    state_d = ST_PUSH;
      ST_PUSH:   state_d = ST_MEAN;
      ST_MEAN:   state_d = ST_OUT;
      ST_OUT:    if (m_axis_tready) state_d = ST_ACC;
      default:   state_d = ST_ACC;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      ST_ACC:  s_axis_tready = 1'b1;
      ST_OUT:  m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign m_axis_tdata = prod_q[MEAN_SHIFT +: PRESS_W];
  assign m_axis_tuser = {ovf_q, |chist_q};

  // ---------------------------------------------------------------------------
  // Control and report state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      axis_q  <= AX_X;
      scale_q <= SCALE_RESET;
      sum_x_q <= '0;
      sum_y_q <= '0;
      sum_z_q <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      step_q  <= '0;
      total_q <= '0;
      chist_q <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        phist_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;

      if (cfg_valid_i && cfg_ready_o) begin
        scale_q <= cfg_data_i;
      end

      // accumulate contacts up to the limit
      if (in_fire && !s_axis_tuser) begin
        if (cnt_q < CNT_W'(MAX_CONTACTS)) begin
          sum_x_q <= sum_x_q + SUM_W'(fx);
          sum_y_q <= sum_y_q + SUM_W'(fy);
          sum_z_q <= sum_z_q + SUM_W'(fz);
          cnt_q   <= cnt_q + CNT_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end

      // step counter shared by divider and square root
      if (div_load || state_q == ST_SQ_ADD) begin
        step_q <= '0;
      end else if (state_q == ST_DIV || state_q == ST_SQRT) begin
        step_q <= step_q + STEP_W'(1);
      end

      // push the newest report into the histories, keep a running total
      if (state_q == ST_PUSH) begin
        for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
          phist_q[i] <= phist_q[i-1];
        end
        phist_q[0] <= newest_q;
        chist_q    <= HISTORY_DEPTH'({chist_q, touched_q});
        total_q    <= total_q + TOT_W'(newest_q) - TOT_W'(phist_q[HISTORY_DEPTH-1]);
      end

      // report finished: start the next one clean
      if (out_fire) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
        sum_z_q <= '0;
        cnt_q   <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Arithmetic datapath (no reset needed)
  always_ff @(posedge clk_i) begin
    // divider
    if (div_load) begin
      dvd_q <= div_src;
      rem_q <= '0;
      den_q <= div_den;
    end else if (state_q == ST_DIV) begin
      dvd_q <= {dvd_q[DIV_W-2:0], div_ge};
      rem_q <= div_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end

    // shared multiplier, registered
    if (state_q == ST_SQUARE || state_q == ST_SCALE || state_q == ST_MEAN) begin
      prod_q <= mul_p;
    end

    // sum of squares and square root
    if (state_q == ST_CHECK) begin
      sq_q      <= '0;
      rrem_q    <= '0;
      root_q    <= '0;
      newest_q  <= '0;
      touched_q <= 1'b0;
    end else if (state_q == ST_SQ_ADD) begin
      sq_q <= sq_q + RAD_W'(prod_q);
    end else if (state_q == ST_SQRT) begin
      sq_q   <= {sq_q[RAD_W-3:0], 2'b00};
      rrem_q <= sqrt_ge ? rrem_sub[ROOT_W+1:0] : rrem_sh[ROOT_W+1:0];
      root_q <= {root_q[ROOT_W-2:0], sqrt_ge};
    end else if (state_q == ST_SAT) begin
      newest_q  <= sat_val;
      touched_q <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_CONTACTS))
    else $error("contact count above limit");

  a_clear_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |=> (cnt_q == '0) && !ovf_q && (sum_x_q == '0))
    else $error("report state not cleared after result transfer");

  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (step_q < STEP_W'(DIV_W)))
    else $error("divider step count overrun");

endmodule
